>>> src/dsc_pkg.sv
// dsc_pkg: shared types and constants for the divisible subarray counter
// holds payload structs, histogram word, controller/datapath command and status
// no dependencies
package dsc_pkg;

    localparam int VALUE_W    = 31;
    localparam int COUNT_W    = 32;
    localparam int MOD_W      = 13;
    localparam int DIVIDEND_W = 32;
    localparam int STEP_W     = $clog2(DIVIDEND_W);
    localparam int HIST_W     = 17;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [HIST_W-1:0]    HIST_MAX      = '1;
    localparam logic [MOD_W-1:0]     MODULUS_RESET = 13'd1;
    localparam logic [PADDR_W-3:0]   REG_MODULUS   = 1'b0;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_last;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic               is_last_res;
    } result_t;

    typedef struct packed {
        logic              tag;
        logic [HIST_W-1:0] count;
    } hist_word_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic item_rd;
        logic item_upd;
        logic clr_wr;
        logic scrub_rd;
        logic scrub_wr;
        logic ptr_rst;
        logic ptr_inc;
        logic epoch_flip;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic ptr_last;
        logic is_last;
    } status_t;

endpackage

>>> src/dsc_ram.sv
// dsc_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module dsc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/dsc_ctrl.sv
// dsc_ctrl: sequencing state machine for the divisible subarray counter
// drives dsc_datapath through dsc_pkg::cmd_t, reads dsc_pkg::status_t
// depends on dsc_pkg
module dsc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    output logic             result_valid,
    input  logic             result_stall,
    output dsc_pkg::cmd_t    cmd,
    input  dsc_pkg::status_t status
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_READ  = 6'b001000,
        S_UPD   = 6'b010000,
        S_SCRUB = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   scrub_done_reg, scrub_done_next;
    logic   phase_reg, phase_next;
    logic   result_valid_reg, result_valid_next;
    logic   scrub_ok;
    logic   out_free;

    always_comb
    begin
        state_next        = state_reg;
        scrub_done_next   = scrub_done_reg;
        phase_next        = 1'b0;
        cmd               = '0;
        scrub_ok          = 1'b0;
        out_free          = !result_valid_reg || !result_stall;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.ptr_last)
                begin
                    cmd.ptr_rst     = 1'b1;
                    scrub_done_next = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                scrub_ok = !scrub_done_reg;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                scrub_ok     = !scrub_done_reg && !status.div_last;
                if (status.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.item_rd = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    cmd.item_upd      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = status.is_last ? S_SCRUB : S_IDLE;
                end
            end
            S_SCRUB:
            begin
                scrub_ok = !scrub_done_reg;
                if (scrub_done_reg)
                begin
                    cmd.epoch_flip  = 1'b1;
                    cmd.ptr_rst     = 1'b1;
                    scrub_done_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // background sweep retags stale entries, read then conditional write
        if (scrub_ok)
        begin
            if (!phase_reg)
            begin
                cmd.scrub_rd = 1'b1;
                phase_next   = 1'b1;
            end
            else
            begin
                cmd.scrub_wr = 1'b1;
                if (status.ptr_last)
                begin
                    cmd.ptr_rst     = 1'b1;
                    scrub_done_next = 1'b1;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            scrub_done_reg   <= 1'b0;
            phase_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scrub_done_reg   <= scrub_done_next;
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

>>> src/dsc_datapath.sv
// dsc_datapath: residue divider, histogram ram, running total and output register
// depends on dsc_pkg and dsc_ram, commanded by dsc_ctrl
module dsc_datapath #(
    parameter int MAX_MOD = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsc_pkg::cmd_t                 cmd,
    output dsc_pkg::status_t              status,
    input  logic [dsc_pkg::MOD_W-1:0]     modulus,
    input  dsc_pkg::item_t                item,
    output dsc_pkg::result_t              result
);

    localparam int IDX_W  = $clog2(MAX_MOD);
    localparam int SUM_W  = dsc_pkg::COUNT_W + 1;
    localparam int WORD_W = $bits(dsc_pkg::hist_word_t);

    logic [dsc_pkg::MOD_W-1:0]      mod_eff;
    logic [dsc_pkg::MOD_W-1:0]      mod_eff_reg;
    logic [dsc_pkg::DIVIDEND_W-1:0] dividend_reg;
    logic [dsc_pkg::MOD_W-1:0]      rem_reg;
    logic [dsc_pkg::MOD_W-1:0]      rem_step;
    logic [dsc_pkg::MOD_W:0]        trial;
    logic [dsc_pkg::STEP_W-1:0]     div_cnt_reg;
    logic                           last_reg;
    logic [IDX_W-1:0]               prefix_reg;
    logic [dsc_pkg::COUNT_W-1:0]    total_reg;
    logic [dsc_pkg::COUNT_W-1:0]    total_new;
    logic                           epoch_reg;
    logic [IDX_W-1:0]               ptr_reg;
    dsc_pkg::result_t               result_reg;

    logic [IDX_W-1:0]               idx;
    logic [dsc_pkg::HIST_W-1:0]     cur_count;
    logic [dsc_pkg::HIST_W-1:0]     inc_count;
    logic [SUM_W-1:0]               add;
    logic [SUM_W-1:0]               sum;

    logic                           ram_we;
    logic [IDX_W-1:0]               ram_waddr;
    dsc_pkg::hist_word_t            ram_wdata;
    logic                           ram_re;
    logic [IDX_W-1:0]               ram_raddr;
    logic [WORD_W-1:0]              ram_rdata;
    dsc_pkg::hist_word_t            rd_word;

    // zero acts as one, values past the table depth clamp to it
    always_comb
    begin
        if (modulus == '0)
        begin
            mod_eff = dsc_pkg::MOD_W'(1);
        end
        else if (32'(modulus) > 32'(MAX_MOD))
        begin
            mod_eff = dsc_pkg::MOD_W'(MAX_MOD);
        end
        else
        begin
            mod_eff = modulus;
        end
    end

    // restoring remainder, one dividend bit per step
    always_comb
    begin
        trial = {rem_reg, dividend_reg[dsc_pkg::DIVIDEND_W-1]};
        if (trial >= {1'b0, mod_eff_reg})
        begin
            rem_step = dsc_pkg::MOD_W'(trial - {1'b0, mod_eff_reg});
        end
        else
        begin
            rem_step = dsc_pkg::MOD_W'(trial);
        end
    end

    assign idx     = IDX_W'(rem_reg);
    assign rd_word = dsc_pkg::hist_word_t'(ram_rdata);

    always_comb
    begin
        cur_count = (rd_word.tag == epoch_reg) ? rd_word.count : '0;
        inc_count = (cur_count == dsc_pkg::HIST_MAX) ? cur_count
                                                      : cur_count + dsc_pkg::HIST_W'(1);
        // the empty prefix counts when the residue is zero
        add       = SUM_W'(cur_count) + SUM_W'(rem_reg == '0);
        sum       = SUM_W'(total_reg) + add;
        total_new = sum[dsc_pkg::COUNT_W] ? '1 : sum[dsc_pkg::COUNT_W-1:0];
    end

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata.tag   = epoch_reg;
        ram_wdata.count = '0;
        if (cmd.item_upd)
        begin
            ram_we          = 1'b1;
            ram_waddr       = idx;
            ram_wdata.count = inc_count;
        end
        else if (cmd.clr_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.scrub_wr && (rd_word.tag != epoch_reg))
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = cmd.item_rd || cmd.scrub_rd;
    assign ram_raddr = cmd.item_rd ? idx : ptr_reg;

    dsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_MOD)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg  <= '0;
            total_reg   <= '0;
            epoch_reg   <= 1'b0;
            ptr_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                div_cnt_reg <= dsc_pkg::STEP_W'(dsc_pkg::DIVIDEND_W - 1);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - dsc_pkg::STEP_W'(1);
            end

            if (cmd.item_upd)
            begin
                total_reg  <= last_reg ? '0 : total_new;
                prefix_reg <= last_reg ? '0 : idx;
            end

            if (cmd.epoch_flip)
            begin
                epoch_reg <= ~epoch_reg;
            end

            if (cmd.ptr_rst)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mod_eff_reg  <= mod_eff;
            dividend_reg <= dsc_pkg::DIVIDEND_W'(prefix_reg)
                          + dsc_pkg::DIVIDEND_W'(item.value);
            rem_reg      <= '0;
            last_reg     <= item.is_last;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[dsc_pkg::DIVIDEND_W-2:0], 1'b0};
            rem_reg      <= rem_step;
        end

        if (cmd.item_upd)
        begin
            result_reg.pair_count  <= total_new;
            result_reg.is_last_res <= last_reg;
        end
    end

    assign status.div_last = (div_cnt_reg == '0);
    assign status.ptr_last = (ptr_reg == IDX_W'(MAX_MOD - 1));
    assign status.is_last  = last_reg;
    assign result          = result_reg;

endmodule

>>> src/divisible_subarray_counter_unit.sv
// divisible_subarray_counter_unit: top level, apb register and block wiring
// depends on dsc_pkg, dsc_ctrl, dsc_datapath, dsc_ram
//
//   port group      direction   handshake                     payload
//   apb config      in/out      psel, penable, pready         paddr, pwdata, prdata
//   item            in          item_valid / item_stall       dsc_pkg::item_t
//   result          out         result_valid / result_stall   dsc_pkg::result_t
//
// each item passes accept, divider steps, histogram read and update in that order,
// and the next item is taken only once its update is done; the divider is bit-serial
// after reset every histogram entry is cleared while item_stall is high
// after a last item the input waits until the sweep that retags stale entries
// is through; the sweep otherwise runs while idle and while items divide
// a stalled result holds the update, and no item is taken while it waits
module divisible_subarray_counter_unit #(
    parameter int MAX_MOD = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [dsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [dsc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  dsc_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output dsc_pkg::result_t              result
);

    logic [dsc_pkg::MOD_W-1:0]     cfg_modulus_reg, cfg_modulus_next;
    logic [dsc_pkg::PADDR_W-3:0]   reg_sel;
    logic                          cfg_wr;
    dsc_pkg::cmd_t                 cmd;
    dsc_pkg::status_t              status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[dsc_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        cfg_modulus_next = cfg_modulus_reg;
        prdata           = '0;
        unique case (reg_sel)
            dsc_pkg::REG_MODULUS:
            begin
                prdata = dsc_pkg::PDATA_W'(cfg_modulus_reg);
                if (cfg_wr)
                begin
                    cfg_modulus_next = pwdata[dsc_pkg::MOD_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_modulus_reg <= dsc_pkg::MODULUS_RESET;
        end
        else
        begin
            cfg_modulus_reg <= cfg_modulus_next;
        end
    end

    dsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    dsc_datapath #(
        .MAX_MOD (MAX_MOD)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .modulus (cfg_modulus_reg),
        .item    (item),
        .result  (result)
    );

endmodule

>>> src/dsc_checker.sv
// dsc_checker: port-level assertions for divisible_subarray_counter_unit
// depends on dsc_pkg, bound to the top level below
module dsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [dsc_pkg::PADDR_W-1:0]   paddr,
    input logic [dsc_pkg::PDATA_W-1:0]   pwdata,
    input logic [dsc_pkg::PDATA_W-1:0]   prdata,
    input logic                          pready,
    input logic                          item_valid,
    input logic                          item_stall,
    input dsc_pkg::item_t                item,
    input logic                          result_valid,
    input logic                          result_stall,
    input dsc_pkg::result_t              result
);

    // nothing taken or shown while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> item_stall && !result_valid)
        else $error("item or result active during reset");

    // stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second item taken while one is in flight");

    // a result cannot follow its item on the very next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> !$rose(result_valid))
        else $error("result appeared before the residue was formed");

endmodule

bind divisible_subarray_counter_unit dsc_checker u_dsc_checker (.*);
